// ===== rtl/core/mevh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mevh_pkg
// Shared widths, codes and tables of the perceptron value head.
// ----------------------------------------------------------------------------
package mevh_pkg;

   localparam int VAL_W     = 16;
   localparam int CSR_IDX_W = 4;

   localparam logic OP_PARAM   = 1'b0;
   localparam logic OP_FEATURE = 1'b1;

   localparam logic [1:0] LAYER_FIRST  = 2'd0;
   localparam logic [1:0] LAYER_SECOND = 2'd1;
   localparam logic [1:0] LAYER_OUTPUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COUNT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_COUNT  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_COUNT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOGIT_COUNT  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_ZERO   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_ONE    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_TWO    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_THREE  = 4'd7;

   // log2(e) in Q16
   localparam logic [16:0] EXP_LOG2E = 17'd94548;

   // 2^(-i/16) in Q15
   function automatic logic [15:0] pow2_frac(input logic [4:0] idx);
      logic [15:0] v;
      case (idx)
         5'd0:  v = 16'd32768;
         5'd1:  v = 16'd31379;
         5'd2:  v = 16'd30048;
         5'd3:  v = 16'd28774;
         5'd4:  v = 16'd27554;
         5'd5:  v = 16'd26386;
         5'd6:  v = 16'd25268;
         5'd7:  v = 16'd24196;
         5'd8:  v = 16'd23170;
         5'd9:  v = 16'd22188;
         5'd10: v = 16'd21247;
         5'd11: v = 16'd20347;
         5'd12: v = 16'd19484;
         5'd13: v = 16'd18658;
         5'd14: v = 16'd17867;
         5'd15: v = 16'd17109;
         5'd16: v = 16'd16384;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat16(input logic signed [47:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 48'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -48'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mevh_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mevh_req_if
// Input channel: parameter words and feature elements.
// ----------------------------------------------------------------------------
interface mevh_req_if import mevh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [1:0]              layer_select;
   logic [6:0]              row_index;
   logic [7:0]              column_index;
   logic                    is_bias;
   logic signed [VAL_W-1:0] item_value;
   logic                    last_feature;

   modport source (output valid, operation, layer_select, row_index, column_index,
                   is_bias, item_value, last_feature, input ready);
   modport sink   (input valid, operation, layer_select, row_index, column_index,
                   is_bias, item_value, last_feature, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mevh_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mevh_rsp_if
// Result channel: one value per evaluation.
// ----------------------------------------------------------------------------
interface mevh_rsp_if import mevh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] position_value;

   modport source (output valid, position_value, input ready);
   modport sink   (input valid, position_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mevh_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mevh_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface mevh_csr_if import mevh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [VAL_W-1:0]     write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mlp_expected_value_head_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_expected_value_head_top
// Three-layer fixed-point perceptron with SiLU and softmax-weighted score sum.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req_ch   in   parameter word or feature element
//  rsp_ch   out  position_value, one per last feature
//  csr_ch   in   register index and data, always ready
//
//  A last feature runs the evaluation on one shared MAC fed from the weight
//  memories, layer by layer: per neuron a bias load and the MAC pass, then
//  SiLU on hidden neurons (exp table and a 34-step divider), and a softmax
//  tail per logit. Reset clears control only; stores start undefined. req_ch
//  is held off during evaluation; a result waits in the output register while
//  new beats are taken.
// ----------------------------------------------------------------------------
module mlp_expected_value_head_top import mevh_pkg::*; #(
   parameter int MAX_INPUTS = 256,
   parameter int MAX_HIDDEN = 128,
   parameter int MAX_LOGITS = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mevh_req_if.sink    req_ch,
   mevh_rsp_if.source  rsp_ch,
   mevh_csr_if.sink    csr_ch
);

   localparam int MAX_DIM = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
   localparam int CW      = $clog2(MAX_DIM + 1);
   localparam int RW      = $clog2(MAX_HIDDEN);
   localparam int LW      = $clog2(MAX_LOGITS + 1);
   localparam int KW      = (MAX_LOGITS > 1) ? $clog2(MAX_LOGITS) : 1;
   localparam int W1N     = MAX_HIDDEN * MAX_INPUTS;
   localparam int W2N     = MAX_HIDDEN * MAX_HIDDEN;
   localparam int W3N     = MAX_LOGITS * MAX_HIDDEN;
   localparam int BN      = 2 * MAX_HIDDEN + MAX_LOGITS;
   localparam int HN      = 2 * MAX_HIDDEN;
   localparam int W1A     = $clog2(W1N);
   localparam int W2A     = $clog2(W2N);
   localparam int W3A     = $clog2(W3N);
   localparam int BA      = $clog2(BN);
   localparam int HA      = $clog2(HN);
   localparam int FA      = $clog2(MAX_INPUTS);
   localparam int PW      = $clog2(MAX_INPUTS + 1);
   localparam int WBW     = (W1A > W2A) ? W1A : W2A;

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_LAYER  = 18'h00002,
      S_BIAS   = 18'h00004,
      S_LOADB  = 18'h00008,
      S_MAC    = 18'h00010,
      S_DRAIN  = 18'h00020,
      S_ROUND  = 18'h00040,
      S_EXPMUL = 18'h00080,
      S_EXPINT = 18'h00100,
      S_EXPSHF = 18'h00200,
      S_DIV    = 18'h00400,
      S_SIGMUL = 18'h00800,
      S_SIGRND = 18'h01000,
      S_SMAX   = 18'h02000,
      S_SMUL   = 18'h04000,
      S_SADD   = 18'h08000,
      S_SQ     = 18'h10000,
      S_FIN    = 18'h20000
   } state_type;

   // memories
   logic signed [VAL_W-1:0] first_weights [W1N];
   logic signed [VAL_W-1:0] second_weights [W2N];
   logic signed [VAL_W-1:0] output_weights [W3N];
   logic signed [VAL_W-1:0] bias_store [BN];
   logic signed [VAL_W-1:0] feature_buffer [MAX_INPUTS];
   logic signed [VAL_W-1:0] hidden_buffer [HN];

   logic signed [VAL_W-1:0] w1_q_ff, w2_q_ff, w3_q_ff, bias_q_ff, feat_q_ff, hid_q_ff;

   logic           w1_we, w2_we, w3_we, bias_we, feat_we, hid_we;
   logic [W1A-1:0] w1_wa;
   logic [W2A-1:0] w2_wa;
   logic [W3A-1:0] w3_wa;
   logic [BA-1:0]  bias_wa, bias_ra;
   logic [HA-1:0]  hid_wa, hid_ra;
   logic [WBW-1:0] w_ra;
   logic signed [VAL_W-1:0] hid_wd;

   // control
   state_type     state_ff, state_in;
   logic [PW-1:0] pos_ff;
   logic [1:0]    layer_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic [WBW-1:0] wbase_ff;
   logic [KW-1:0] k_ff;
   logic [5:0]    cnt_ff;
   logic          pipe1_ff, pipe2_ff;
   logic          rsp_valid_ff;

   // registers
   logic [8:0]              in_cnt_ff;
   logic [7:0]              h1_cnt_ff, h2_cnt_ff;
   logic [2:0]              lo_cnt_ff;
   logic signed [VAL_W-1:0] score_ff [4];

   // datapath
   logic signed [31:0]      prod_ff;
   logic signed [39:0]      acc_ff;
   logic signed [VAL_W-1:0] x_ff;
   logic [16:0]             t_ff;
   logic [33:0]             u_ff;
   logic [31:0]             frac_ff;
   logic [15:0]             base_ff;
   logic [3:0]              shift_ff;
   logic                    ezero_ff;
   logic [15:0]             e_ff;
   logic [33:0]             div_num_ff;
   logic [17:0]             div_den_ff;
   logic [18:0]             div_rem_ff;
   logic signed [33:0]      sig_prod_ff;
   logic signed [VAL_W-1:0] logits_ff [MAX_LOGITS];
   logic signed [VAL_W-1:0] m_ff;
   logic [17:0]             tot_ff;
   logic signed [33:0]      sprod_ff, snum_ff;
   logic                    neg_ff;
   logic signed [VAL_W-1:0] rsp_val_ff;

   logic req_acc, csr_acc;
   logic [31:0] n_in32, n_h132, n_h232, n_lo32;
   logic [CW-1:0] n_in, n_h1, n_h2, cur_n, cur_rows;
   logic [LW-1:0] n_lo;
   logic row_last, col_last, neuron_done_first;
   logic [WBW-1:0] stride;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign csr_acc = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.position_value = rsp_val_ff;

   // counts in use
   always_comb begin
      n_in32 = (32'(in_cnt_ff) > 32'(MAX_INPUTS)) ? 32'(MAX_INPUTS) : 32'(in_cnt_ff);
      n_h132 = (32'(h1_cnt_ff) > 32'(MAX_HIDDEN)) ? 32'(MAX_HIDDEN) : 32'(h1_cnt_ff);
      n_h232 = (32'(h2_cnt_ff) > 32'(MAX_HIDDEN)) ? 32'(MAX_HIDDEN) : 32'(h2_cnt_ff);
      n_lo32 = (32'(lo_cnt_ff) > 32'(MAX_LOGITS)) ? 32'(MAX_LOGITS) : 32'(lo_cnt_ff);
      if (n_lo32 == 32'd0) begin
         n_lo32 = 32'd1;
      end
      n_in = n_in32[CW-1:0];
      n_h1 = n_h132[CW-1:0];
      n_h2 = n_h232[CW-1:0];
      n_lo = n_lo32[LW-1:0];
      case (layer_ff)
         LAYER_FIRST: begin
            cur_n = n_in;
            cur_rows = n_h1;
            stride = WBW'(MAX_INPUTS);
         end
         LAYER_SECOND: begin
            cur_n = n_h1;
            cur_rows = n_h2;
            stride = WBW'(MAX_HIDDEN);
         end
         default: begin
            cur_n = n_h2;
            cur_rows = CW'(n_lo);
            stride = WBW'(MAX_HIDDEN);
         end
      endcase
      row_last = (CW'(row_ff) + CW'(1)) == cur_rows;
      col_last = (col_ff + CW'(1)) == cur_n;
      neuron_done_first = (cur_n == CW'(0));
   end

   // parameter writes and read addresses
   always_comb begin
      logic [31:0] r32, c32, a32;
      r32 = 32'(req_ch.row_index);
      c32 = 32'(req_ch.column_index);
      w1_we = 1'b0;
      w2_we = 1'b0;
      w3_we = 1'b0;
      bias_we = 1'b0;
      w1_wa = W1A'(r32 * MAX_INPUTS + c32);
      w2_wa = W2A'(r32 * MAX_HIDDEN + c32);
      w3_wa = W3A'(r32 * MAX_HIDDEN + c32);
      bias_wa = BA'(r32);
      if (req_acc && req_ch.operation == OP_PARAM) begin
         case (req_ch.layer_select)
            LAYER_FIRST: begin
               if (r32 < 32'(MAX_HIDDEN)) begin
                  if (req_ch.is_bias) begin
                     bias_we = 1'b1;
                  end else if (c32 < 32'(MAX_INPUTS)) begin
                     w1_we = 1'b1;
                  end
               end
            end
            LAYER_SECOND: begin
               bias_wa = BA'(r32 + 32'(MAX_HIDDEN));
               if (r32 < 32'(MAX_HIDDEN)) begin
                  if (req_ch.is_bias) begin
                     bias_we = 1'b1;
                  end else if (c32 < 32'(MAX_HIDDEN)) begin
                     w2_we = 1'b1;
                  end
               end
            end
            LAYER_OUTPUT: begin
               bias_wa = BA'(r32 + 32'(2 * MAX_HIDDEN));
               if (r32 < 32'(MAX_LOGITS)) begin
                  if (req_ch.is_bias) begin
                     bias_we = 1'b1;
                  end else if (c32 < 32'(MAX_HIDDEN)) begin
                     w3_we = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      feat_we = req_acc && req_ch.operation == OP_FEATURE && 32'(pos_ff) < 32'(MAX_INPUTS);

      case (layer_ff)
         LAYER_FIRST:  a32 = 32'(row_ff);
         LAYER_SECOND: a32 = 32'(row_ff) + 32'(MAX_HIDDEN);
         default:      a32 = 32'(row_ff) + 32'(2 * MAX_HIDDEN);
      endcase
      bias_ra = BA'(a32);
      w_ra = wbase_ff + WBW'(col_ff);
      if (layer_ff == LAYER_OUTPUT) begin
         hid_ra = HA'(32'(col_ff) + 32'(MAX_HIDDEN));
      end else begin
         hid_ra = HA'(col_ff);
      end
      hid_we = (state_ff == S_SIGRND);
      if (layer_ff == LAYER_FIRST) begin
         hid_wa = HA'(row_ff);
      end else begin
         hid_wa = HA'(32'(row_ff) + 32'(MAX_HIDDEN));
      end
   end

   always_ff @(posedge clock) begin
      if (w1_we) begin
         first_weights[w1_wa] <= req_ch.item_value;
      end
      w1_q_ff <= first_weights[w_ra[W1A-1:0]];
   end

   always_ff @(posedge clock) begin
      if (w2_we) begin
         second_weights[w2_wa] <= req_ch.item_value;
      end
      w2_q_ff <= second_weights[w_ra[W2A-1:0]];
   end

   always_ff @(posedge clock) begin
      if (w3_we) begin
         output_weights[w3_wa] <= req_ch.item_value;
      end
      w3_q_ff <= output_weights[w_ra[W3A-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_store[bias_wa] <= req_ch.item_value;
      end
      bias_q_ff <= bias_store[bias_ra];
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feature_buffer[pos_ff[FA-1:0]] <= req_ch.item_value;
      end
      feat_q_ff <= feature_buffer[col_ff[FA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (hid_we) begin
         hidden_buffer[hid_wa] <= hid_wd;
      end
      hid_q_ff <= hidden_buffer[hid_ra];
   end

   // datapath helpers
   logic signed [47:0] acc_rnd, sig_rnd;
   logic signed [VAL_W-1:0] x_in, w_sel, v_sel, m_in, score_sel;
   logic [15:0] e_in, tab0, tab1;
   logic [16:0] den_in, q17, s17;
   logic [18:0] rem_next;
   logic [33:0] mag;
   logic signed [16:0] e_s;
   logic signed [17:0] s_s;

   always_comb begin
      acc_rnd = acc_ff;
      acc_rnd = (acc_rnd + 48'sd1024) >>> 11;
      x_in = sat16(acc_rnd);
      sig_rnd = sig_prod_ff;
      sig_rnd = (sig_rnd + 48'sd16384) >>> 15;
      hid_wd = sat16(sig_rnd);
      case (layer_ff)
         LAYER_FIRST:  w_sel = w1_q_ff;
         LAYER_SECOND: w_sel = w2_q_ff;
         default:      w_sel = w3_q_ff;
      endcase
      v_sel = (layer_ff == LAYER_FIRST) ? feat_q_ff : hid_q_ff;
      tab0 = pow2_frac({1'b0, u_ff[26:23]});
      tab1 = pow2_frac({1'b0, u_ff[26:23]} + 5'd1);
      e_in = ezero_ff ? 16'd0 : ((base_ff - frac_ff[31:16]) >> shift_ff);
      den_in = 17'd32768 + 17'(e_in);
      rem_next = {div_rem_ff[17:0], div_num_ff[33]};
      q17 = div_num_ff[16:0];
      s17 = x_ff[VAL_W-1] ? (17'd32768 - q17) : q17;
      s_s = $signed({1'b0, s17});
      e_s = $signed({1'b0, e_ff});
      score_sel = score_ff[2'(k_ff)];
      m_in = logits_ff[0];
      for (int i = 1; i < MAX_LOGITS; i++) begin
         if (32'(i) < 32'(n_lo) && logits_ff[i] > m_in) begin
            m_in = logits_ff[i];
         end
      end
      mag = snum_ff[33] ? 34'(-snum_ff) : 34'(snum_ff);
   end

   // control path
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_ch.operation == OP_FEATURE && req_ch.last_feature) begin
               state_in = S_LAYER;
            end
         end
         S_LAYER: begin
            if (cur_rows != CW'(0)) begin
               state_in = S_BIAS;
            end
         end
         S_BIAS:   state_in = S_LOADB;
         S_LOADB:  state_in = neuron_done_first ? S_DRAIN : S_MAC;
         S_MAC:    state_in = col_last ? S_DRAIN : S_MAC;
         S_DRAIN:  state_in = (!pipe1_ff && !pipe2_ff) ? S_ROUND : S_DRAIN;
         S_ROUND: begin
            if (layer_ff != LAYER_OUTPUT) begin
               state_in = S_EXPMUL;
            end else if (row_last) begin
               state_in = S_SMAX;
            end else begin
               state_in = S_BIAS;
            end
         end
         S_EXPMUL: state_in = S_EXPINT;
         S_EXPINT: state_in = S_EXPSHF;
         S_EXPSHF: state_in = (layer_ff == LAYER_OUTPUT) ? S_SMUL : S_DIV;
         S_DIV: begin
            if (cnt_ff == 6'd33) begin
               state_in = (layer_ff == LAYER_OUTPUT) ? S_FIN : S_SIGMUL;
            end
         end
         S_SIGMUL: state_in = S_SIGRND;
         S_SIGRND: state_in = row_last ? S_LAYER : S_BIAS;
         S_SMAX:   state_in = S_EXPMUL;
         S_SMUL:   state_in = S_SADD;
         S_SADD:   state_in = ((LW'(k_ff) + LW'(1)) == n_lo) ? S_SQ : S_EXPMUL;
         S_SQ:     state_in = S_DIV;
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0;
         layer_ff <= LAYER_FIRST;
         row_ff <= '0;
         col_ff <= '0;
         wbase_ff <= '0;
         k_ff <= '0;
         cnt_ff <= '0;
         pipe1_ff <= 1'b0;
         pipe2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_cnt_ff <= 9'd150;
         h1_cnt_ff <= 8'd128;
         h2_cnt_ff <= 8'd128;
         lo_cnt_ff <= 3'd4;
         for (int i = 0; i < 4; i++) begin
            score_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pipe1_ff <= (state_ff == S_MAC);
         pipe2_ff <= pipe1_ff;
         if (state_ff == S_FIN && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_acc) begin
            case (csr_ch.reg_index)
               REG_INPUT_COUNT:  in_cnt_ff <= csr_ch.write_data[8:0];
               REG_FIRST_COUNT:  h1_cnt_ff <= csr_ch.write_data[7:0];
               REG_SECOND_COUNT: h2_cnt_ff <= csr_ch.write_data[7:0];
               REG_LOGIT_COUNT:  lo_cnt_ff <= csr_ch.write_data[2:0];
               REG_SCORE_ZERO:   score_ff[0] <= csr_ch.write_data;
               REG_SCORE_ONE:    score_ff[1] <= csr_ch.write_data;
               REG_SCORE_TWO:    score_ff[2] <= csr_ch.write_data;
               REG_SCORE_THREE:  score_ff[3] <= csr_ch.write_data;
               default: begin
               end
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc && req_ch.operation == OP_FEATURE && req_ch.last_feature) begin
                  pos_ff <= '0;
                  layer_ff <= LAYER_FIRST;
                  row_ff <= '0;
                  wbase_ff <= '0;
               end else if (feat_we) begin
                  pos_ff <= pos_ff + PW'(1);
               end
            end
            S_LAYER: begin
               if (cur_rows == CW'(0)) begin
                  layer_ff <= layer_ff + 2'd1;
               end
            end
            S_LOADB: col_ff <= '0;
            S_MAC:   col_ff <= col_ff + CW'(1);
            S_ROUND: begin
               if (layer_ff == LAYER_OUTPUT) begin
                  row_ff <= row_ff + RW'(1);
                  wbase_ff <= wbase_ff + stride;
               end
            end
            S_EXPSHF: cnt_ff <= '0;
            S_SQ:     cnt_ff <= '0;
            S_DIV:    cnt_ff <= cnt_ff + 6'd1;
            S_SIGRND: begin
               if (row_last) begin
                  row_ff <= '0;
                  wbase_ff <= '0;
                  layer_ff <= layer_ff + 2'd1;
               end else begin
                  row_ff <= row_ff + RW'(1);
                  wbase_ff <= wbase_ff + stride;
               end
            end
            S_SMAX: k_ff <= '0;
            S_SADD: k_ff <= k_ff + KW'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pipe1_ff) begin
         prod_ff <= w_sel * v_sel;
      end
      if (state_ff == S_LOADB) begin
         acc_ff <= 40'(bias_q_ff) <<< 11;
      end else if (pipe2_ff) begin
         acc_ff <= acc_ff + 40'(prod_ff);
      end
      case (state_ff)
         S_ROUND: begin
            x_ff <= x_in;
            t_ff <= x_in[VAL_W-1] ? 17'(-18'(x_in)) : 17'(x_in);
            if (layer_ff == LAYER_OUTPUT) begin
               logits_ff[KW'(row_ff)] <= x_in;
            end
         end
         S_EXPMUL: u_ff <= 34'(t_ff) * 34'(EXP_LOG2E);
         S_EXPINT: begin
            frac_ff <= 32'(tab0 - tab1) * 32'(u_ff[22:7]);
            base_ff <= tab0;
            shift_ff <= u_ff[30:27];
            ezero_ff <= |u_ff[33:31];
         end
         S_EXPSHF: begin
            e_ff <= e_in;
            div_num_ff <= 34'(1 << 30) + 34'(den_in >> 1);
            div_den_ff <= 18'(den_in);
            div_rem_ff <= '0;
         end
         S_DIV: begin
            if (rem_next >= {1'b0, div_den_ff}) begin
               div_rem_ff <= rem_next - {1'b0, div_den_ff};
               div_num_ff <= {div_num_ff[32:0], 1'b1};
            end else begin
               div_rem_ff <= rem_next;
               div_num_ff <= {div_num_ff[32:0], 1'b0};
            end
         end
         S_SIGMUL: sig_prod_ff <= x_ff * s_s;
         S_SMAX: begin
            m_ff <= m_in;
            t_ff <= 17'(18'(m_in) - 18'(logits_ff[0]));
            tot_ff <= '0;
            snum_ff <= '0;
         end
         S_SMUL: begin
            sprod_ff <= e_s * score_sel;
            tot_ff <= tot_ff + 18'(e_ff);
         end
         S_SADD: begin
            snum_ff <= snum_ff + sprod_ff;
            t_ff <= 17'(18'(m_ff) - 18'(logits_ff[KW'(k_ff + KW'(1))]));
         end
         S_SQ: begin
            neg_ff <= snum_ff[33];
            div_num_ff <= mag + 34'(tot_ff >> 1);
            div_den_ff <= tot_ff;
            div_rem_ff <= '0;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (neg_ff) begin
                  rsp_val_ff <= (div_num_ff > 34'd32768) ? 16'sh8000
                                                        : 16'(-17'(div_num_ff[16:0]));
               end else begin
                  rsp_val_ff <= (div_num_ff > 34'd32767) ? 16'sh7FFF : 16'(div_num_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the perceptron value head against a bit-accurate predictor.
// The weights and biases for the sizes in use are loaded first, then
// wide-input, directed, random and back-pressure runs compare each position
// value with the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
   import mevh_pkg::*;

   localparam int N_IN  = 256;
   localparam int N_HID = 128;
   localparam int N_LOG = 4;
   localparam int LOAD_IN  = 12;
   localparam int LOAD_HID = 8;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 200;

   localparam longint EXP2_Q15 [17] = '{32768, 31379, 30048, 28774, 27554, 26386,
      25268, 24196, 23170, 22188, 21247, 20347, 19484, 18658, 17867, 17109, 16384};
   localparam logic [15:0] REG_MASK [8] = '{16'h1FF, 16'hFF, 16'hFF, 16'h7,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mevh_req_if req_if();
   mevh_rsp_if rsp_if();
   mevh_csr_if csr_if();

   mlp_expected_value_head_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] w_first  [N_HID*N_IN];
   logic signed [15:0] w_second [N_HID*N_HID];
   logic signed [15:0] w_output [N_LOG*N_HID];
   logic signed [15:0] bias_mem [2*N_HID+N_LOG];
   logic signed [15:0] features [N_IN];
   logic signed [15:0] hidden   [2*N_HID];
   int                 feat_pos;
   logic [15:0]        csr_regs [8];

   logic signed [15:0] expected_values[$];
   bit                 failed = 1'b0;
   bit                 calm = 1'b0;
   int                 hold_left = 0;
   longint             cycles = 0;

   function automatic longint sat_q(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint exp_neg_q15(longint t);
      longint u, n, f, idx, rem, a, b;
      u = t * 94548;
      n = u >> 27;
      if (n >= 16) return 0;
      f = u & 64'h7FFFFFF;
      idx = f >> 23;
      rem = (f >> 7) & 64'hFFFF;
      a = EXP2_Q15[idx];
      b = EXP2_Q15[idx+1];
      return (a - (((a - b) * rem) >> 16)) >> n;
   endfunction

   function automatic longint silu_q(longint x);
      longint mag, den, s;
      mag = (x < 0) ? -x : x;
      den = 32768 + exp_neg_q15(mag);
      s = ((longint'(1) << 30) + den / 2) / den;
      if (x < 0) s = 32768 - s;
      return sat_q(round_sh(x * s, 15));
   endfunction

   function automatic longint acc_to_q(longint acc);
      logic signed [39:0] w;
      w = acc[39:0];
      return sat_q(round_sh(longint'(w), 11));
   endfunction

   function automatic int clamp_cnt(logic [15:0] v, int maxv);
      return (int'(v) > maxv) ? maxv : int'(v);
   endfunction

   function automatic logic signed [15:0] position_value_of();
      int n_in, n_h1, n_h2, n_lo;
      longint acc, logit[N_LOG], m, e, num, total, mag, q;
      n_in = clamp_cnt(csr_regs[REG_INPUT_COUNT], N_IN);
      n_h1 = clamp_cnt(csr_regs[REG_FIRST_COUNT], N_HID);
      n_h2 = clamp_cnt(csr_regs[REG_SECOND_COUNT], N_HID);
      n_lo = clamp_cnt(csr_regs[REG_LOGIT_COUNT], N_LOG);
      if (n_lo == 0) n_lo = 1;
      for (int r = 0; r < n_h1; r++) begin
         acc = longint'(bias_mem[r]) * 2048;
         for (int i = 0; i < n_in; i++)
            acc += longint'(w_first[r*N_IN+i]) * longint'(features[i]);
         hidden[r] = 16'(silu_q(acc_to_q(acc)));
      end
      for (int r = 0; r < n_h2; r++) begin
         acc = longint'(bias_mem[N_HID+r]) * 2048;
         for (int i = 0; i < n_h1; i++)
            acc += longint'(w_second[r*N_HID+i]) * longint'(hidden[i]);
         hidden[N_HID+r] = 16'(silu_q(acc_to_q(acc)));
      end
      for (int k = 0; k < n_lo; k++) begin
         acc = longint'(bias_mem[2*N_HID+k]) * 2048;
         for (int i = 0; i < n_h2; i++)
            acc += longint'(w_output[k*N_HID+i]) * longint'(hidden[N_HID+i]);
         logit[k] = acc_to_q(acc);
      end
      m = logit[0];
      for (int k = 1; k < n_lo; k++)
         if (logit[k] > m) m = logit[k];
      num = 0;
      total = 0;
      for (int k = 0; k < n_lo; k++) begin
         e = exp_neg_q15(m - logit[k]);
         total += e;
         num += e * longint'($signed(csr_regs[REG_SCORE_ZERO + k]));
      end
      mag = (num < 0) ? -num : num;
      q = (mag + total / 2) / total;
      if (num < 0) q = -q;
      return 16'(sat_q(q));
   endfunction

   function automatic void model_beat(logic op, logic [1:0] layer, logic [6:0] row,
                                      logic [7:0] col, logic bias, logic signed [15:0] v,
                                      logic last);
      if (op == OP_PARAM) begin
         if (layer == LAYER_FIRST) begin
            if (bias) bias_mem[row] = v;
            else w_first[row*N_IN+col] = v;
         end else if (layer == LAYER_SECOND) begin
            if (bias) bias_mem[N_HID+row] = v;
            else if (col < N_HID) w_second[row*N_HID+col] = v;
         end else if (layer == LAYER_OUTPUT && row < N_LOG) begin
            if (bias) bias_mem[2*N_HID+row] = v;
            else if (col < N_HID) w_output[row*N_HID+col] = v;
         end
      end else begin
         if (feat_pos < N_IN) begin
            features[feat_pos] = v;
            feat_pos++;
         end
         if (last) begin
            expected_values.push_back(position_value_of());
            feat_pos = 0;
         end
      end
   endfunction

   function automatic logic signed [15:0] rand_val();
      int p;
      p = $urandom_range(99);
      if (p < 5) return 16'sh7FFF;
      if (p < 10) return 16'sh8000;
      if (p < 25) return 16'($urandom);
      return $signed(16'($urandom_range(2047))) - 16'sd1024;
   endfunction

   task automatic send_beat(logic op, logic [1:0] layer, logic [6:0] row, logic [7:0] col,
                            logic bias, logic signed [15:0] v, logic last);
      while (!calm && $urandom_range(99) < 16) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid        = 1'b1;
      req_if.operation    = op;
      req_if.layer_select = layer;
      req_if.row_index    = row;
      req_if.column_index = col;
      req_if.is_bias      = bias;
      req_if.item_value   = v;
      req_if.last_feature = last;
      do @(posedge clock); while (!req_if.ready);
      model_beat(op, layer, row, col, bias, v, last);
   endtask

   task automatic send_param(logic [1:0] layer, int row, int col, logic bias,
                             logic signed [15:0] v);
      send_beat(OP_PARAM, layer, 7'(row), 8'(col), bias, v, 1'($urandom));
   endtask

   task automatic send_features(int count);
      for (int i = 0; i < count; i++)
         send_beat(OP_FEATURE, 2'($urandom), 7'($urandom), 8'($urandom), 1'($urandom),
                   rand_val(), i == count - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_if.valid      = 1'b1;
      csr_if.reg_index  = idx;
      csr_if.write_data = data;
      do @(posedge clock); while (!csr_if.ready);
      if (idx <= REG_SCORE_THREE) csr_regs[idx] = data & REG_MASK[idx];
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_sizes(int n_in, int n_h1, int n_h2, int n_lo);
      settle();
      write_reg(REG_INPUT_COUNT, 16'(n_in));
      write_reg(REG_FIRST_COUNT, 16'(n_h1));
      write_reg(REG_SECOND_COUNT, 16'(n_h2));
      write_reg(REG_LOGIT_COUNT, 16'(n_lo));
      write_reg(REG_SCORE_ZERO, rand_val());
      write_reg(REG_SCORE_ONE, rand_val());
      write_reg(REG_SCORE_TWO, rand_val());
      write_reg(REG_SCORE_THREE, rand_val());
   endtask

   // small weights in the first two layers keep the deep layers out of saturation; row 0 of the
   // first layer is filled across every input for the wide runs
   task automatic test_load_all();
      for (int r = 0; r < LOAD_HID; r++) begin
         send_param(LAYER_FIRST, r, $urandom, 1'b1, rand_val());
         send_param(LAYER_SECOND, r, $urandom, 1'b1, rand_val());
         for (int c = 0; c < LOAD_IN; c++)
            send_param(LAYER_FIRST, r, c, 1'b0, $signed(16'($urandom_range(255))) - 16'sd128);
         for (int c = 0; c < LOAD_HID; c++)
            send_param(LAYER_SECOND, r, c, 1'b0, $signed(16'($urandom_range(511))) - 16'sd256);
      end
      for (int k = 0; k < N_LOG; k++) begin
         send_param(LAYER_OUTPUT, k, $urandom, 1'b1, rand_val());
         for (int c = 0; c < LOAD_HID; c++)
            send_param(LAYER_OUTPUT, k, c, 1'b0, rand_val());
      end
      for (int c = LOAD_IN; c < N_IN; c++)
         send_param(LAYER_FIRST, 0, c, 1'b0, $signed(16'($urandom_range(255))) - 16'sd128);
   endtask

   task automatic test_wide_input();
      set_sizes(300, 1, 1, 1);
      send_features(N_IN + 2);
      set_sizes(N_IN, 1, 1, 7);
      send_features(5);
   endtask

   task automatic test_directed();
      set_sizes(3, 2, 2, 2);
      write_reg(REG_SCORE_ZERO, 16'h7FFF);
      write_reg(REG_SCORE_ONE, 16'h8000);
      write_reg(REG_SCORE_THREE + 1, 16'h1234);
      send_param(LAYER_FIRST, 0, 0, 1'b0, 16'sh7FFF);
      send_param(LAYER_FIRST, 1, 2, 1'b0, 16'sh8000);
      send_param(LAYER_FIRST, 127, 255, 1'b1, 16'sh8000);
      send_param(2'd3, 0, 0, 1'b0, 16'sh7FFF);
      send_param(LAYER_OUTPUT, 5, 0, 1'b1, 16'sh7FFF);
      send_param(LAYER_SECOND, 0, 200, 1'b0, 16'sh7FFF);
      send_param(LAYER_OUTPUT, 1, 130, 1'b0, 16'sh8000);
      send_beat(OP_FEATURE, 2'd0, 7'd0, 8'd0, 1'b0, 16'sh7FFF, 1'b0);
      send_beat(OP_FEATURE, 2'd0, 7'd0, 8'd0, 1'b0, 16'sh8000, 1'b0);
      send_beat(OP_FEATURE, 2'd3, 7'h7F, 8'hFF, 1'b1, 16'sh0000, 1'b1);
      send_features(1);
      set_sizes(0, 0, 0, 0);
      send_features(2);
      set_sizes(1, 1, 1, 7);
      send_features(1);
   endtask

   task automatic test_random_traffic();
      int beats, n_in, n_h, p;
      beats = 0;
      for (int phase = 0; beats < 290; phase++) begin
         p = $urandom_range(99);
         n_in = (p < 85) ? $urandom_range(1, 8) : (p < 96) ? $urandom_range(9, LOAD_IN) : 0;
         n_h = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(0, LOAD_HID);
         set_sizes(n_in, n_h, $urandom_range(0, 6), $urandom_range(0, 7));
         calm = (phase == 3);
         for (int ev = 0; ev < 8; ev++) begin
            for (int j = $urandom_range(0, 4); j > 0; j--) begin
               p = $urandom_range(99);
               if (p < 85)
                  send_param(2'($urandom_range(0, 2)), $urandom_range(0, 7),
                             $urandom_range(0, 9), 1'($urandom_range(99) < 30), rand_val());
               else
                  send_param(2'($urandom), $urandom, $urandom, 1'($urandom), rand_val());
               beats++;
            end
            p = $urandom_range(1, (n_in > 0 ? n_in : 1) + 2);
            send_features(p);
            beats += p;
         end
      end
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      set_sizes(4, 3, 3, 4);
      hold_left = 500;
      for (int ev = 0; ev < 6; ev++) send_features($urandom_range(1, 5));
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      for (int ev = 0; ev < 4; ev++) send_features($urandom_range(1, 5));
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_if.ready = calm || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_values.size() == 0) begin
            $error("position_value: no result expected, actual %0d", rsp_if.position_value);
            failed = 1'b1;
         end else if (rsp_if.position_value !== expected_values[0]) begin
            $error("position_value: expected %0d, actual %0d", expected_values[0],
                   rsp_if.position_value);
            failed = 1'b1;
            void'(expected_values.pop_front());
         end else begin
            void'(expected_values.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.operation = OP_PARAM;
      req_if.layer_select = LAYER_FIRST;
      req_if.row_index = '0;
      req_if.column_index = '0;
      req_if.is_bias = 1'b0;
      req_if.item_value = '0;
      req_if.last_feature = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = REG_INPUT_COUNT;
      csr_if.write_data = '0;
      csr_regs = '{16'd150, 16'd128, 16'd128, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0};
      feat_pos = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_all();
      test_wide_input();
      test_directed();
      test_random_traffic();
      test_backpressure();
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed && expected_values.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mevh_pkg.sv
rtl/core/mevh_req_if.sv
rtl/core/mevh_rsp_if.sv
rtl/core/mevh_csr_if.sv
rtl/core/mlp_expected_value_head_top.sv
sim/tb_top.sv
